@@ rtl/rgba_transfer_function_lookup_unit_macros.svh @@
// assertion macros for the rgba transfer function lookup checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RGBA_TRANSFER_FUNCTION_LOOKUP_UNIT_MACROS_SVH
`define RGBA_TRANSFER_FUNCTION_LOOKUP_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define RTFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RTFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rtfl_pkg.sv @@
// shared constants, types and helpers of the rgba transfer function lookup
// no dependencies
`timescale 1ns / 1ps

package rtfl_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MIN_POINTS = 2;
  localparam int POS_W      = 16;
  localparam int CH_W       = 16;
  localparam int NUM_CH     = 4;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CFG_W      = $clog2(MAX_POINTS + 1);
  localparam int CH_SEL_W   = $clog2(NUM_CH);
  localparam int NUM_W      = POS_W + CH_W;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = CH_W / DIV_BITS;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [CH_W-1:0]     ch_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [CH_SEL_W-1:0] ch_sel_t;
  typedef logic [NUM_W-1:0]    num_t;

  // table write port
  typedef struct packed {
    logic   en;
    idx_t   addr;
    pos_t   pos;
    color_t color;
  } tbl_wr_t;

  // divider request
  typedef struct packed {
    logic start;
    num_t num;
    pos_t den;
  } div_req_t;

  // one channel out of a packed color, red in the low bits
  function automatic ch_t chan_of(color_t c, ch_sel_t sel);
    chan_of = c[sel * CH_W +: CH_W];
  endfunction

endpackage

@@ rtl/rtfl_if.sv @@
// valid/ready channel interfaces for lookup items and results
// depends on rtfl_pkg
`timescale 1ns / 1ps

interface rtfl_in_if;
  import rtfl_pkg::*;

  logic valid;
  logic ready;
  logic opcode;
  idx_t point_index;
  pos_t sample_value;
  ch_t  red_in;
  ch_t  green_in;
  ch_t  blue_in;
  ch_t  alpha_in;

  modport source (output valid, opcode, point_index, sample_value,
                  red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, opcode, point_index, sample_value,
                  red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rtfl_out_if;
  import rtfl_pkg::*;

  logic valid;
  logic ready;
  ch_t  red_out;
  ch_t  green_out;
  ch_t  blue_out;
  ch_t  alpha_out;
  idx_t segment_end;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  segment_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                  segment_end, output ready);
endinterface

@@ rtl/rgba_transfer_function_lookup_unit.sv @@
// RGBA transfer function lookup: a table of up to 16 control points (16-bit
// position, four 16-bit color channels) with piecewise linear interpolation.
// A write item stores one point and gives no result. A lookup item clamps
// the sample to the first and last points in use, scans the table one entry
// per cycle for the segment, then computes each channel with one shared
// 16x16 multiplier and one shared divider that yields two quotient bits per
// cycle. A lookup holds the input from acceptance until the result is
// registered; the scan visits no entry for two points and at most the point
// count in use minus two, and the four channel divisions run serially. A
// segment of zero width returns the upper point's color without the
// multiplier and divider.
// A result not yet taken by the receiver holds the next lookup in its last step.
// Depends on rtfl_pkg, rtfl_if, rtfl_table and rtfl_div.
`timescale 1ns / 1ps

module rgba_transfer_function_lookup_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  rtfl_in_if.sink                      in_ch,
  rtfl_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [rtfl_pkg::CFG_W-1:0]   cfg_wdata
);
  import rtfl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_SEARCH, ST_GET_HI, ST_GET_LO, ST_CLAMP,
    ST_WEIGHT, ST_MUL_LO, ST_MUL_HI, ST_SUM, ST_DIV_WAIT, ST_DONE
  } state_t;

  state_t           state_r;
  logic [CFG_W-1:0] point_count_r;
  logic [CFG_W-1:0] n_eff;
  logic [CFG_W-1:0] n_m1;
  idx_t             last_idx;

  pos_t    s_r;
  idx_t    idx_r;
  idx_t    k_r;
  pos_t    p1_r;
  pos_t    p2_r;
  color_t  c1_r;
  color_t  c2_r;
  pos_t    d_r;
  pos_t    wlo_r;
  pos_t    whi_r;
  logic    zero_w_r;
  ch_sel_t ch_r;
  num_t    mul_r;
  num_t    acc_r;
  ch_t     res_r [NUM_CH];

  logic    out_valid_r;
  ch_t     out_red_r;
  ch_t     out_green_r;
  ch_t     out_blue_r;
  ch_t     out_alpha_r;
  idx_t    out_seg_r;

  logic     in_acc;
  logic     out_free;
  logic     found;
  logic     last_probe;
  logic     ch_last;
  idx_t     idx_inc;
  idx_t     rd_addr;
  pos_t     rd_pos;
  color_t   rd_col;
  ch_t      mul_a;
  pos_t     mul_b;
  num_t     prod;
  tbl_wr_t  tbl_wr;
  div_req_t div_req;
  logic     div_done;
  ch_t      div_q;

  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // point count in use, out-of-range values clamp
  always_comb begin
    priority if (point_count_r < CFG_W'(MIN_POINTS)) begin
      n_eff = CFG_W'(MIN_POINTS);
    end else if (point_count_r > CFG_W'(MAX_POINTS)) begin
      n_eff = CFG_W'(MAX_POINTS);
    end else begin
      n_eff = point_count_r;
    end
  end

  assign n_m1     = n_eff - CFG_W'(1);
  assign last_idx = n_m1[IDX_W-1:0];

  // segment search decisions
  assign idx_inc    = idx_r + IDX_W'(1);
  assign found      = (rd_pos >= s_r);
  assign last_probe = (CFG_W'(idx_inc) == n_m1);
  assign ch_last    = (ch_r == CH_SEL_W'(NUM_CH - 1));

  // table read address per sequencer step
  always_comb begin
    unique case (state_r)
      ST_IDLE:   rd_addr = '0;
      ST_FIRST:  rd_addr = last_idx;
      ST_LAST:   rd_addr = IDX_W'(1);
      ST_SEARCH: rd_addr = found ? idx_r : idx_inc;
      ST_GET_HI: rd_addr = k_r - IDX_W'(1);
      default:   rd_addr = '0;
    endcase
  end

  // table write from a write item
  assign tbl_wr.en    = in_acc && (in_ch.opcode == OP_WRITE);
  assign tbl_wr.addr  = in_ch.point_index;
  assign tbl_wr.pos   = in_ch.sample_value;
  assign tbl_wr.color = {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  rtfl_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_pos  (rd_pos),
    .rd_col  (rd_col)
  );

  // shared multiplier: lower color by upper distance, then upper by lower
  assign mul_a = (state_r == ST_MUL_HI) ? chan_of(c2_r, ch_r) : chan_of(c1_r, ch_r);
  assign mul_b = (state_r == ST_MUL_HI) ? whi_r : wlo_r;
  assign prod  = mul_a * mul_b;

  // shared divider
  assign div_req.start = (state_r == ST_SUM);
  assign div_req.num   = acc_r + mul_r;
  assign div_req.den   = d_r;

  rtfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CFG_W'(MIN_POINTS);
    end else if (cfg_we) begin
      point_count_r <= cfg_wdata;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken, unless a new one loads in the same cycle
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_ch.opcode == OP_LOOKUP)) begin
            state_r <= ST_FIRST;
          end
        end
        ST_FIRST: state_r <= ST_LAST;
        ST_LAST: begin
          if (n_eff == CFG_W'(MIN_POINTS)) begin
            state_r <= ST_GET_HI;
          end else begin
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (found || last_probe) begin
            state_r <= ST_GET_HI;
          end
        end
        ST_GET_HI: state_r <= ST_GET_LO;
        ST_GET_LO: state_r <= ST_CLAMP;
        ST_CLAMP:  state_r <= ST_WEIGHT;
        ST_WEIGHT: state_r <= ST_MUL_LO;
        ST_MUL_LO: begin
          if (zero_w_r) begin
            if (ch_last) begin
              state_r <= ST_DONE;
            end
          end else begin
            state_r <= ST_MUL_HI;
          end
        end
        ST_MUL_HI: state_r <= ST_SUM;
        ST_SUM:    state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            state_r <= ch_last ? ST_DONE : ST_MUL_LO;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= res_r[0];
            out_green_r <= res_r[1];
            out_blue_r  <= res_r[2];
            out_alpha_r <= res_r[3];
            out_seg_r   <= k_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        s_r <= in_ch.sample_value;
      end
      // clamp to the first position
      ST_FIRST: begin
        if (s_r < rd_pos) begin
          s_r <= rd_pos;
        end
      end
      // clamp to the last position
      ST_LAST: begin
        if (s_r > rd_pos) begin
          s_r <= rd_pos;
        end
        idx_r <= IDX_W'(1);
        k_r   <= IDX_W'(1);
      end
      ST_SEARCH: begin
        if (found) begin
          k_r <= idx_r;
        end else begin
          k_r <= idx_inc;
        end
        idx_r <= idx_inc;
      end
      ST_GET_HI: begin
        p2_r <= rd_pos;
        c2_r <= rd_col;
      end
      ST_GET_LO: begin
        p1_r <= rd_pos;
        c1_r <= rd_col;
      end
      // clamp into the segment, width and zero-width flag
      ST_CLAMP: begin
        zero_w_r <= !(p2_r > p1_r);
        d_r      <= p2_r - p1_r;
        ch_r     <= '0;
        if (p2_r > p1_r) begin
          if (s_r < p1_r) begin
            s_r <= p1_r;
          end else if (s_r > p2_r) begin
            s_r <= p2_r;
          end
        end
      end
      ST_WEIGHT: begin
        wlo_r <= p2_r - s_r;
        whi_r <= s_r - p1_r;
      end
      ST_MUL_LO: begin
        if (zero_w_r) begin
          res_r[ch_r] <= chan_of(c2_r, ch_r);
          ch_r        <= ch_r + CH_SEL_W'(1);
        end else begin
          mul_r <= prod;
        end
      end
      ST_MUL_HI: begin
        acc_r <= mul_r;
        mul_r <= prod;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_r[ch_r] <= div_q;
          ch_r        <= ch_r + CH_SEL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // port drive
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_out     = out_red_r;
  assign out_ch.green_out   = out_green_r;
  assign out_ch.blue_out    = out_blue_r;
  assign out_ch.alpha_out   = out_alpha_r;
  assign out_ch.segment_end = out_seg_r;

endmodule

@@ rtl/rtfl_table.sv @@
// control point table: positions and packed colors, one write and one read port
// depends on rtfl_pkg
`timescale 1ns / 1ps

module rtfl_table (
  input  logic             clk,
  input  rtfl_pkg::tbl_wr_t wr,
  input  rtfl_pkg::idx_t   rd_addr,
  output rtfl_pkg::pos_t   rd_pos,
  output rtfl_pkg::color_t rd_col
);
  import rtfl_pkg::*;

  pos_t   pos_mem [MAX_POINTS];
  color_t col_mem [MAX_POINTS];
  pos_t   rd_pos_r;
  color_t rd_col_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pos_mem[wr.addr] <= wr.pos;
      col_mem[wr.addr] <= wr.color;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_pos_r <= pos_mem[rd_addr];
    rd_col_r <= col_mem[rd_addr];
  end

  assign rd_pos = rd_pos_r;
  assign rd_col = rd_col_r;

endmodule

@@ rtl/rtfl_div.sv @@
// iterative restoring divider, two quotient bits per cycle
// depends on rtfl_pkg; quotient must fit in CH_W bits
`timescale 1ns / 1ps

module rtfl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rtfl_pkg::div_req_t req,
  output logic               done,
  output rtfl_pkg::ch_t      quot
);
  import rtfl_pkg::*;

  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  pos_t              rem_r;
  pos_t              den_r;
  ch_t               q_r;
  pos_t              rem_nxt;
  ch_t               q_nxt;

  // DIV_BITS compare-subtract steps per cycle
  always_comb begin
    logic [POS_W:0] trial;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {rem_nxt, q_nxt[CH_W-1]};
      q_nxt = {q_nxt[CH_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial    = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = trial[POS_W-1:0];
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // remainder and quotient shift register, high half starts as remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[NUM_W-1:CH_W];
      q_r   <= req.num[CH_W-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ rtl/rtfl_checker.sv @@
// port-level checks of the rgba transfer function lookup, bound to the top level
// depends on rtfl_pkg and rgba_transfer_function_lookup_unit_macros.svh
`timescale 1ns / 1ps
`include "rgba_transfer_function_lookup_unit_macros.svh"

module rtfl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_opcode,
  input logic           out_valid,
  input logic           out_ready,
  input rtfl_pkg::ch_t  out_red,
  input rtfl_pkg::ch_t  out_green,
  input rtfl_pkg::ch_t  out_blue,
  input rtfl_pkg::ch_t  out_alpha,
  input rtfl_pkg::idx_t out_seg
);
  import rtfl_pkg::*;

  // a stalled result stays put
  `RTFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha) && $stable(out_seg), "stalled result changed")

  // a lookup item keeps the block busy
  `RTFL_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (in_opcode == OP_LOOKUP), !in_ready, "ready right after a lookup item")

  // a write item leaves the block ready in the next cycle
  `RTFL_ASSERT_NEXT(a_write_quick, in_valid && in_ready && (in_opcode == OP_WRITE), in_ready, "not ready after a write item")

  // the segment end is never the first point
  `RTFL_ASSERT_NOW(a_seg_nonzero, out_valid, out_seg != '0, "segment end of zero")

endmodule

bind rgba_transfer_function_lookup_unit rtfl_checker u_rtfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red_out),
  .out_green (out_ch.green_out),
  .out_blue  (out_ch.blue_out),
  .out_alpha (out_ch.alpha_out),
  .out_seg   (out_ch.segment_end)
);
